[hw/rtl/sic_pkg.sv]
// ----------------------------------------------------------------------------
// sic_pkg: shared constants and types of the segment intersection classifier
// Field widths, register map, position codes and stream packing widths.
// ----------------------------------------------------------------------------
package sic_pkg;

  // default coordinate width (two's complement, 8 fraction bits)
  localparam int COORD_BITS_DEF = 24;

  // result fields: cross products with 16 fraction bits
  localparam int OUT_W = 51;
  localparam int POS_W = 3;
  localparam int EPS_W = 20;

  localparam int OUT_FIELDS_W = 3 * OUT_W + 2 * POS_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  // number of register stages from input to output
  localparam int PIPE_DEPTH = 4;

  // 1.0 in the 16 fraction bit product format
  localparam logic signed [OUT_W-1:0] FIXED_ONE = 51'sd65536;

  // configuration port
  localparam int              PADDR_W     = 3;
  localparam int              PDATA_W     = 32;
  localparam logic [0:0]      REG_EPSILON = 1'b0;
  localparam logic [EPS_W-1:0] EPS_RESET  = 20'd1;

  // where num/den lies relative to [0,1]
  typedef enum logic [POS_W-1:0] {
    POS_LT_ZERO  = 3'd0,
    POS_EQ_ZERO  = 3'd1,
    POS_IN_RANGE = 3'd2,
    POS_EQ_ONE   = 3'd3,
    POS_GT_ONE   = 3'd4
  } pos_e;

endpackage

[hw/rtl/segment_intersection_classifier.sv]
// ----------------------------------------------------------------------------
// segment_intersection_classifier: segment pair intersection classifier
// Forms the three cross products of two segments and places both
// intersection parameters relative to [0,1] without a divider.
// ----------------------------------------------------------------------------
//
// Channel  Dir  Handshake          Contents
// s_axis   in   tvalid/tready      eight coordinates a_x..d_y
// m_axis   out  tvalid/tready      numerators, denominator, two positions
// apb      in   psel/penable/pwr.  epsilon register at byte address 0
//
// Throughput is one item per cycle while m_axis is not stalled. The clock is
// set by stage 1: twelve coordinate differences
// feeding six signed (COORD_BITS+1) x (COORD_BITS+1) multipliers.
// Each stage advances when it is empty or the stage after it advances, so
// bubbles are squeezed out and a stalled output does not stop intake until
// all four stages are full. Reset clears the valid bits and sets epsilon to 1.
//
// Stages:
//   0  input register (coordinates)
//   1  differences and products
//   2  cross products, saturation to 51 bits, parallel test on epsilon
//   3  classification, result register
// ----------------------------------------------------------------------------
module segment_intersection_classifier #(
  parameter int COORD_BITS = sic_pkg::COORD_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // a_x, a_y, b_x, b_y, c_x, c_y, d_x, d_y (COORD_BITS each, lowest first)
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [8*COORD_BITS-1:0]          s_axis_tdata,
  // first_numerator, second_numerator, shared_denominator (51 each),
  // first_position, second_position (3 each), one zero pad bit
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [sic_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  // configuration
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [sic_pkg::PADDR_W-1:0]      paddr,
  input  logic [sic_pkg::PDATA_W-1:0]      pwdata,
  output logic [sic_pkg::PDATA_W-1:0]      prdata,
  output logic                             pready
);

  localparam int OW      = sic_pkg::OUT_W;
  localparam int EW      = sic_pkg::EPS_W;
  localparam int DIFF_W  = COORD_BITS + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int CROSS_W = PROD_W + 1;
  localparam int PAD_W   = sic_pkg::OUT_TDATA_W - sic_pkg::OUT_FIELDS_W;

  // coordinate slots in the input item
  localparam int AX = 0;
  localparam int AY = 1;
  localparam int BX = 2;
  localparam int BY = 3;
  localparam int CX = 4;
  localparam int CY = 5;
  localparam int DX = 6;
  localparam int DY = 7;

  localparam logic signed [OW-1:0] OUT_MAX = {1'b0, {(OW-1){1'b1}}};
  localparam logic signed [OW-1:0] OUT_MIN = {1'b1, {(OW-1){1'b0}}};

  // --------------------------------------------------------------------------
  // Configuration register
  // --------------------------------------------------------------------------
  logic [EW-1:0] eps_q;
  logic          reg_sel;
  logic          cfg_wr;

  assign reg_sel = paddr[sic_pkg::PADDR_W-1];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;
  assign prdata  = (reg_sel == sic_pkg::REG_EPSILON) ? sic_pkg::PDATA_W'(eps_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q <= sic_pkg::EPS_RESET;
    end else if (cfg_wr && (reg_sel == sic_pkg::REG_EPSILON)) begin
      eps_q <= pwdata[EW-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline control: a stage loads when empty or when its successor loads
  // --------------------------------------------------------------------------
  logic [sic_pkg::PIPE_DEPTH-1:0] vld_q;
  logic [sic_pkg::PIPE_DEPTH-1:0] adv;

  assign adv[3] = !vld_q[3] || m_axis_tready;
  assign adv[2] = !vld_q[2] || adv[3];
  assign adv[1] = !vld_q[1] || adv[2];
  assign adv[0] = !vld_q[0] || adv[1];

  assign s_axis_tready = adv[0];
  assign m_axis_tvalid = vld_q[3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) vld_q[0] <= s_axis_tvalid;
      if (adv[1]) vld_q[1] <= vld_q[0];
      if (adv[2]) vld_q[2] <= vld_q[1];
      if (adv[3]) vld_q[3] <= vld_q[2];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 0: input register
  // --------------------------------------------------------------------------
  logic signed [COORD_BITS-1:0] coord_q [8];

  always_ff @(posedge clk_i) begin
    if (adv[0] && s_axis_tvalid) begin
      for (int i = 0; i < 8; i++) begin
        coord_q[i] <= s_axis_tdata[i*COORD_BITS +: COORD_BITS];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: differences and the six products
  //   den = (b-a) x (d-c), num1 = (c-a) x (d-a), num2 = (b-c) x (a-c)
  // --------------------------------------------------------------------------
  logic signed [DIFF_W-1:0] ax, ay, bx, by, cx, cy, dx, dy;
  logic signed [DIFF_W-1:0] bax, bay, dcx, dcy, cax, cay, dax, day, bcx, bcy, acx, acy;
  logic signed [PROD_W-1:0] prod_d [6];
  logic signed [PROD_W-1:0] prod_q [6];

  always_comb begin
    ax = DIFF_W'(coord_q[AX]);
    ay = DIFF_W'(coord_q[AY]);
    bx = DIFF_W'(coord_q[BX]);
    by = DIFF_W'(coord_q[BY]);
    cx = DIFF_W'(coord_q[CX]);
    cy = DIFF_W'(coord_q[CY]);
    dx = DIFF_W'(coord_q[DX]);
    dy = DIFF_W'(coord_q[DY]);

    bax = bx - ax;  bay = by - ay;
    dcx = dx - cx;  dcy = dy - cy;
    cax = cx - ax;  cay = cy - ay;
    dax = dx - ax;  day = dy - ay;
    bcx = bx - cx;  bcy = by - cy;
    acx = ax - cx;  acy = ay - cy;

    prod_d[0] = bax * dcy;
    prod_d[1] = bay * dcx;
    prod_d[2] = cax * day;
    prod_d[3] = cay * dax;
    prod_d[4] = bcx * acy;
    prod_d[5] = bcy * acx;
  end

  always_ff @(posedge clk_i) begin
    if (adv[1] && vld_q[0]) begin
      prod_q <= prod_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: cross products, saturation, parallel test
  // index 0 = denominator, 1 = first numerator, 2 = second numerator
  // --------------------------------------------------------------------------
  logic signed [CROSS_W-1:0] cross_w [3];
  logic signed [OW-1:0]      sat_w   [3];

  for (genvar g = 0; g < 3; g++) begin : g_cross
    assign cross_w[g] = CROSS_W'(prod_q[2*g]) - CROSS_W'(prod_q[2*g+1]);

    if (CROSS_W > OW) begin : g_sat
      logic [CROSS_W-OW:0] top;
      assign top = cross_w[g][CROSS_W-1:OW-1];
      // in range only when all bits above the result sign match it
      assign sat_w[g] = ((&top) || !(|top)) ? cross_w[g][OW-1:0] :
                        (top[CROSS_W-OW] ? OUT_MIN : OUT_MAX);
    end else begin : g_ext
      assign sat_w[g] = OW'(cross_w[g]);
    end
  end

  logic [OW-1:0]        den_mag;
  logic                 parallel;
  logic signed [OW-1:0] den_d, num1_d, num2_d;
  logic signed [OW-1:0] den_q, num1_q, num2_q;

  always_comb begin
    den_mag  = sat_w[0][OW-1] ? OW'(-sat_w[0]) : OW'(sat_w[0]);
    parallel = den_mag < OW'(eps_q);
    // parallel segments: zero denominator, both numerators 1.0
    den_d    = parallel ? '0 : sat_w[0];
    num1_d   = parallel ? sic_pkg::FIXED_ONE : sat_w[1];
    num2_d   = parallel ? sic_pkg::FIXED_ONE : sat_w[2];
  end

  always_ff @(posedge clk_i) begin
    if (adv[2] && vld_q[1]) begin
      den_q  <= den_d;
      num1_q <= num1_d;
      num2_q <= num2_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: classification and result register
  // --------------------------------------------------------------------------
  function automatic sic_pkg::pos_e place(input logic signed [OW-1:0] num,
                                          input logic signed [OW-1:0] den,
                                          input logic [EW-1:0]        eps);
    logic signed [OW:0] gap;
    logic [OW-1:0]      num_mag;
    logic [OW:0]        gap_mag;
    logic               den_pos;
    sic_pkg::pos_e      pos;
    gap     = (OW+1)'(num) - (OW+1)'(den);
    num_mag = num[OW-1] ? OW'(-num) : OW'(num);
    gap_mag = gap[OW] ? (OW+1)'(-gap) : (OW+1)'(gap);
    den_pos = !den[OW-1] && (den != '0);
    if (num_mag < OW'(eps)) begin
      pos = sic_pkg::POS_EQ_ZERO;
    end else if (gap_mag < (OW+1)'(eps)) begin
      pos = sic_pkg::POS_EQ_ONE;
    end else if (den_pos) begin
      if (num[OW-1])      pos = sic_pkg::POS_LT_ZERO;
      else if (num > den) pos = sic_pkg::POS_GT_ONE;
      else                pos = sic_pkg::POS_IN_RANGE;
    end else begin
      if (!num[OW-1] && (num != '0)) pos = sic_pkg::POS_LT_ZERO;
      else if (num < den)            pos = sic_pkg::POS_GT_ONE;
      else                           pos = sic_pkg::POS_IN_RANGE;
    end
    return pos;
  endfunction

  logic signed [OW-1:0] out_den_q, out_num1_q, out_num2_q;
  sic_pkg::pos_e        out_pos1_q, out_pos2_q;

  always_ff @(posedge clk_i) begin
    if (adv[3] && vld_q[2]) begin
      out_den_q  <= den_q;
      out_num1_q <= num1_q;
      out_num2_q <= num2_q;
      out_pos1_q <= place(num1_q, den_q, eps_q);
      out_pos2_q <= place(num2_q, den_q, eps_q);
    end
  end

  assign m_axis_tdata = {{PAD_W{1'b0}},
                         sic_pkg::POS_W'(out_pos2_q), sic_pkg::POS_W'(out_pos1_q),
                         out_den_q, out_num2_q, out_num1_q};

endmodule

[hw/rtl/sic_checker.sv]
// ----------------------------------------------------------------------------
// sic_checker: port-level checks for the segment intersection classifier
// Tracks items in flight and the epsilon register from the ports alone.
// ----------------------------------------------------------------------------
module sic_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [sic_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  input logic                             psel,
  input logic                             penable,
  input logic                             pwrite,
  input logic [sic_pkg::PADDR_W-1:0]      paddr,
  input logic [sic_pkg::PDATA_W-1:0]      pwdata,
  input logic                             pready
);

  localparam int OW = sic_pkg::OUT_W;
  localparam int PW = sic_pkg::POS_W;
  localparam int CW = $clog2(sic_pkg::PIPE_DEPTH + 1);

  logic                        in_acc, out_acc;
  logic [CW-1:0]               cnt_q;
  logic [sic_pkg::EPS_W-1:0]   eps_q;
  logic signed [OW-1:0]        num1, num2, den;
  logic [PW-1:0]               pos1, pos2;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  assign num1 = m_axis_tdata[0 +: OW];
  assign num2 = m_axis_tdata[OW +: OW];
  assign den  = m_axis_tdata[2*OW +: OW];
  assign pos1 = m_axis_tdata[3*OW +: PW];
  assign pos2 = m_axis_tdata[3*OW+PW +: PW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      eps_q <= sic_pkg::EPS_RESET;
    end else begin
      cnt_q <= cnt_q + CW'(in_acc) - CW'(out_acc);
      if (psel && penable && pwrite && pready &&
          (paddr[sic_pkg::PADDR_W-1] == sic_pkg::REG_EPSILON)) begin
        eps_q <= pwdata[sic_pkg::EPS_W-1:0];
      end
    end
  end

  // a result is offered until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result withdrawn before it was taken");

  // no result without an accepted item behind it
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> cnt_q != '0)
    else $error("result without a pending item");

  // never more items inside than pipeline stages
  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(sic_pkg::PIPE_DEPTH))
    else $error("more items in flight than stages");

  // an empty output stage never blocks intake
  a_intake: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with an empty output");

  // a zero denominator under a nonzero tolerance is the parallel case
  a_parallel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (den == '0) && (eps_q != '0) && (eps_q <= 20'd65536)
    |-> (num1 == sic_pkg::FIXED_ONE) && (num2 == sic_pkg::FIXED_ONE) &&
        (pos1 == PW'(sic_pkg::POS_LT_ZERO)) && (pos2 == PW'(sic_pkg::POS_LT_ZERO)))
    else $error("parallel result malformed");

endmodule

bind segment_intersection_classifier sic_checker u_sic_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .psel          (psel),
  .penable       (penable),
  .pwrite        (pwrite),
  .paddr         (paddr),
  .pwdata        (pwdata),
  .pready        (pready)
);
